@@ sv/ps2mct_pkg.sv @@
// Package for the mouse cursor tracker: payload structs, byte phase codes,
// configuration register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package ps2mct_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int OUT_COORD_BITS = 12;
	localparam int CFG_IDX_BITS   = 2;

	typedef logic [OUT_COORD_BITS-1:0] out_coord_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		out_coord_t cursor_x;
		out_coord_t cursor_y;
		logic [2:0] buttons;
	} result_t;

	// Opcodes.
	localparam logic OP_RX_BYTE = 1'b0;
	localparam logic OP_INIT    = 1'b1;

	// Byte phase codes within a three-byte packet.
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DX     = 2'd1;
	localparam logic [1:0] PH_DY     = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_X = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_Y = 2'd3;

	localparam int MAX_X_RST  = 639;
	localparam int MAX_Y_RST  = 479;
	localparam int HOME_X_RST = 320;
	localparam int HOME_Y_RST = 240;

	localparam logic [2:0] BUTTON_MASK = 3'h7;

endpackage

@@ sv/ps2mct_clamp.sv @@
// Adds or subtracts a signed 8-bit mouse delta to a cursor coordinate and
// saturates the sum to 0..limit. Depends on nothing.
`timescale 1ns / 1ps

module ps2mct_clamp #(
	parameter int COORD_BITS = 12
) (
	input  logic [COORD_BITS-1:0] pos,
	input  logic [7:0]            delta,
	input  logic                  subtract,
	input  logic [COORD_BITS-1:0] limit,
	output logic [COORD_BITS-1:0] clamped
);

	// Two extra bits hold the sign and the carry of the sum.
	localparam int SumBits = COORD_BITS + 2;

	logic [SumBits-1:0] pos_ext;
	logic [SumBits-1:0] delta_ext;
	logic [SumBits-1:0] sum;

	assign pos_ext   = {2'b00, pos};
	assign delta_ext = {{(SumBits-8){delta[7]}}, delta};
	assign sum       = subtract ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

	always_comb begin
		if (sum[SumBits-1]) begin
			clamped = '0;
		end else if (sum[SumBits-2:0] > {1'b0, limit}) begin
			clamped = limit;
		end else begin
			clamped = sum[COORD_BITS-1:0];
		end
	end

endmodule

@@ sv/ps2_mouse_cursor_tracker_unit.sv @@
// Top level of the mouse cursor tracker: input register, packet decode,
// cursor update and result register. Uses ps2mct_pkg and ps2mct_clamp.
//
// Channel   Direction  Handshake                Payload
// item      in         item_valid / item_stall  ps2mct_pkg::item_t
// result    out        result_valid / result_stall  ps2mct_pkg::result_t
// cfg       in         cfg_wr_en                cfg_index, cfg_data
//
// One item is taken per cycle while item_stall is low. A result leaves
// through the input register, where decode and the add-and-clamp run,
// and then the result register. Reset puts every register but the input
// and result payloads to its reset value at once; no clearing pass.
// A stalled result holds the input register only for an item that itself
// produces a result; other items pass under it.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_unit #(
	parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  ps2mct_pkg::item_t                  item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output ps2mct_pkg::result_t                result,
	input  logic                               cfg_wr_en,
	input  logic [ps2mct_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]              cfg_data
);

	// Configuration registers.
	logic [COORD_BITS-1:0] max_x_q, max_y_q, home_x_q, home_y_q;

	// Input register.
	ps2mct_pkg::item_t item_s1;
	logic              valid_s1;

	// Tracker state.
	logic [1:0]            phase_q, phase_d;
	logic [7:0]            held_dx_q, held_dx_d;
	logic [2:0]            btn_q, btn_d;
	logic [2:0]            prev_btn_q, prev_btn_d;
	logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
	logic [COORD_BITS-1:0] pos_y_q, pos_y_d;

	// Result register.
	ps2mct_pkg::result_t result_q;
	logic                result_valid_q;

	logic                  produce;
	logic                  advance;
	logic                  out_load;
	logic                  moved;
	logic [COORD_BITS-1:0] new_x, new_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q  <= COORD_BITS'(ps2mct_pkg::MAX_X_RST);
			max_y_q  <= COORD_BITS'(ps2mct_pkg::MAX_Y_RST);
			home_x_q <= COORD_BITS'(ps2mct_pkg::HOME_X_RST);
			home_y_q <= COORD_BITS'(ps2mct_pkg::HOME_Y_RST);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ps2mct_pkg::CFG_MAX_X:  max_x_q  <= cfg_data;
				ps2mct_pkg::CFG_MAX_Y:  max_y_q  <= cfg_data;
				ps2mct_pkg::CFG_HOME_X: home_x_q <= cfg_data;
				ps2mct_pkg::CFG_HOME_Y: home_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ps2mct_clamp #(
		.COORD_BITS(COORD_BITS)
	) u_clamp_x (
		.pos     (pos_x_q),
		.delta   (held_dx_q),
		.subtract(1'b0),
		.limit   (max_x_q),
		.clamped (new_x)
	);

	// Screen rows grow downward, so a positive mouse Y moves the cursor up.
	ps2mct_clamp #(
		.COORD_BITS(COORD_BITS)
	) u_clamp_y (
		.pos     (pos_y_q),
		.delta   (item_s1.rx_byte),
		.subtract(1'b1),
		.limit   (max_y_q),
		.clamped (new_y)
	);

	assign moved = (held_dx_q != 8'd0) || (item_s1.rx_byte != 8'd0) ||
		(btn_q != prev_btn_q);

	always_comb begin
		phase_d    = phase_q;
		held_dx_d  = held_dx_q;
		btn_d      = btn_q;
		prev_btn_d = prev_btn_q;
		pos_x_d    = pos_x_q;
		pos_y_d    = pos_y_q;
		produce    = 1'b0;
		if (item_s1.opcode == ps2mct_pkg::OP_INIT) begin
			pos_x_d = home_x_q;
			pos_y_d = home_y_q;
			btn_d   = 3'd0;
		end else begin
			unique case (phase_q)
				ps2mct_pkg::PH_HEADER: begin
					prev_btn_d = btn_q;
					btn_d      = item_s1.rx_byte[2:0] & ps2mct_pkg::BUTTON_MASK;
					phase_d    = ps2mct_pkg::PH_DX;
				end
				ps2mct_pkg::PH_DX: begin
					held_dx_d = item_s1.rx_byte;
					phase_d   = ps2mct_pkg::PH_DY;
				end
				ps2mct_pkg::PH_DY: begin
					phase_d = ps2mct_pkg::PH_HEADER;
					if (moved) begin
						produce = 1'b1;
						pos_x_d = new_x;
						pos_y_d = new_y;
					end
				end
				default: begin
					// The spare phase code drops the byte and resynchronizes.
					phase_d = ps2mct_pkg::PH_HEADER;
				end
			endcase
		end
	end

	assign advance    = valid_s1 && (!produce || !result_valid_q || !result_stall);
	assign out_load   = advance && produce;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ps2mct_pkg::PH_DY;
			held_dx_q  <= 8'd0;
			btn_q      <= 3'd0;
			prev_btn_q <= 3'd0;
			pos_x_q    <= COORD_BITS'(ps2mct_pkg::HOME_X_RST);
			pos_y_q    <= COORD_BITS'(ps2mct_pkg::HOME_Y_RST);
		end else if (advance) begin
			phase_q    <= phase_d;
			held_dx_q  <= held_dx_d;
			btn_q      <= btn_d;
			prev_btn_q <= prev_btn_d;
			pos_x_q    <= pos_x_d;
			pos_y_q    <= pos_y_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.cursor_x <= ps2mct_pkg::out_coord_t'(new_x);
			result_q.cursor_y <= ps2mct_pkg::out_coord_t'(new_y);
			result_q.buttons  <= btn_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// A new result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!result_valid_q || !result_stall))
		else $error("result register overwritten while stalled");

	// A loaded result is presented in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> result_valid_q)
		else $error("loaded result not presented");

	// After a movement the kept cursor lies within the limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (pos_x_q <= max_x_q) && (pos_y_q <= max_y_q))
		else $error("cursor outside limits after movement");

	// The init opcode puts the cursor home and clears the buttons.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.opcode == ps2mct_pkg::OP_INIT) |=>
		(btn_q == 3'd0) && (pos_x_q == $past(home_x_q)) &&
		(pos_y_q == $past(home_y_q)))
		else $error("init opcode did not home the cursor");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for ps2_mouse_cursor_tracker_unit: directed and random
// mouse byte streams, checked against a cycle-free cursor predictor.
// Depends on ps2mct_pkg and the RTL of the tracker.
`timescale 1ns / 1ps

module testbench;

	localparam int CB             = ps2mct_pkg::COORD_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 6;
	localparam int ROUND_ITEMS    = 150;

	logic                                clk;
	logic                                arst_n;
	logic                                item_valid;
	logic                                item_stall;
	ps2mct_pkg::item_t                   item;
	logic                                result_valid;
	logic                                result_stall;
	ps2mct_pkg::result_t                 result;
	logic                                cfg_wr_en;
	logic [ps2mct_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [CB-1:0]                       cfg_data;

	ps2_mouse_cursor_tracker_unit #(.COORD_BITS(CB)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Predictor state: window registers, packet framing and cursor.
	ps2mct_pkg::out_coord_t lim_x, lim_y, home_col, home_row;
	ps2mct_pkg::out_coord_t cur_x, cur_y;
	logic [1:0]             pkt_phase;
	logic [7:0]             held_dx;
	logic [2:0]             btn_now, btn_prev;
	ps2mct_pkg::result_t    pending_moves[$];
	ps2mct_pkg::result_t    oldest_move;

	int errors          = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int quiet_cycles    = 0;
	bit tx_bursts       = 1'b1;
	bit rx_bursts       = 1'b1;
	bit hold_request    = 1'b0;
	bit holding         = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic ps2mct_pkg::out_coord_t clamp_axis(input int v,
			input ps2mct_pkg::out_coord_t limit);
		if (v < 0)
			return '0;
		if (v > int'(limit))
			return limit;
		return ps2mct_pkg::out_coord_t'(v);
	endfunction

	function automatic ps2mct_pkg::out_coord_t rand_coord(input int unsigned hi);
		return ps2mct_pkg::out_coord_t'($urandom_range(0, hi));
	endfunction

	// Advances the predictor by one accepted item and queues the cursor
	// result that it causes, if any.
	function automatic void track_cursor(input ps2mct_pkg::item_t it);
		int                  dx;
		int                  dy;
		ps2mct_pkg::result_t moved;
		if (it.opcode == ps2mct_pkg::OP_INIT) begin
			cur_x   = home_col;
			cur_y   = home_row;
			btn_now = '0;
			return;
		end
		case (pkt_phase)
			ps2mct_pkg::PH_HEADER: begin
				btn_prev  = btn_now;
				btn_now   = it.rx_byte[2:0] & ps2mct_pkg::BUTTON_MASK;
				pkt_phase = ps2mct_pkg::PH_DX;
			end
			ps2mct_pkg::PH_DX: begin
				held_dx   = it.rx_byte;
				pkt_phase = ps2mct_pkg::PH_DY;
			end
			ps2mct_pkg::PH_DY: begin
				pkt_phase = ps2mct_pkg::PH_HEADER;
				dx = int'($signed(held_dx));
				dy = int'($signed(it.rx_byte));
				if (dx != 0 || dy != 0 || btn_now != btn_prev) begin
					// The mouse reports Y upward, the screen counts rows downward.
					cur_x = clamp_axis(int'(cur_x) + dx, lim_x);
					cur_y = clamp_axis(int'(cur_y) - dy, lim_y);
					moved.cursor_x = cur_x;
					moved.cursor_y = cur_y;
					moved.buttons  = btn_now;
					pending_moves.push_back(moved);
				end
			end
			default: pkt_phase = ps2mct_pkg::PH_HEADER;
		endcase
	endfunction

	task automatic send_item(input logic op, input logic [7:0] data);
		@(negedge clk);
		if (tx_bursts && $urandom_range(0, 4) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		item.opcode  = op;
		item.rx_byte = data;
		item_valid   = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		track_cursor(item);
		items_sent++;
	endtask

	task automatic send_packet(input logic [7:0] header, input logic [7:0] dx,
			input logic [7:0] dy);
		send_item(ps2mct_pkg::OP_RX_BYTE, header);
		send_item(ps2mct_pkg::OP_RX_BYTE, dx);
		send_item(ps2mct_pkg::OP_RX_BYTE, dy);
	endtask

	function automatic logic [7:0] pick_delta();
		case ($urandom_range(0, 7))
			0, 1:    return 8'h00;
			2:       return 8'h7F;
			3:       return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Half of the headers repeat the current buttons so that zero-motion
	// packets can be silent.
	function automatic logic [7:0] pick_header();
		logic [7:0] hdr;
		hdr = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 1) == 1)
			hdr[2:0] = btn_now;
		return hdr;
	endfunction

	// Lowers valid, waits for every expected result and lets any silent
	// item still inside the block finish.
	task automatic drain_results;
		@(negedge clk);
		item_valid = 1'b0;
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ps2mct_pkg::CFG_IDX_BITS-1:0] idx,
			input ps2mct_pkg::out_coord_t val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		case (idx)
			ps2mct_pkg::CFG_MAX_X:  lim_x    = val;
			ps2mct_pkg::CFG_MAX_Y:  lim_y    = val;
			ps2mct_pkg::CFG_HOME_X: home_col = val;
			ps2mct_pkg::CFG_HOME_Y: home_row = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_cursor_window(input ps2mct_pkg::out_coord_t mx,
			input ps2mct_pkg::out_coord_t my, input ps2mct_pkg::out_coord_t hx,
			input ps2mct_pkg::out_coord_t hy);
		drain_results();
		write_reg(ps2mct_pkg::CFG_MAX_X, mx);
		write_reg(ps2mct_pkg::CFG_MAX_Y, my);
		write_reg(ps2mct_pkg::CFG_HOME_X, hx);
		write_reg(ps2mct_pkg::CFG_HOME_Y, hy);
	endtask

	task automatic test_reset_defaults;
		// Framing comes out of reset at the delta Y slot, so one byte closes a packet.
		send_item(ps2mct_pkg::OP_RX_BYTE, 8'h05);
		// Sign and overflow bits of the header must not reach the buttons.
		send_packet(8'hFF, 8'h7F, 8'h80);
		send_packet(8'h07, 8'h7F, 8'h00);
		send_packet(8'h07, 8'h00, 8'h00);
		send_packet(8'h02, 8'h00, 8'h00);
		// An init command in the middle of a packet leaves the framing alone.
		send_item(ps2mct_pkg::OP_RX_BYTE, 8'h02);
		send_item(ps2mct_pkg::OP_INIT, 8'hA5);
		send_item(ps2mct_pkg::OP_RX_BYTE, 8'h80);
		send_item(ps2mct_pkg::OP_RX_BYTE, 8'h7F);
		send_packet(8'h00, 8'h80, 8'h7F);
		send_packet(8'h00, 8'h80, 8'h7F);
	endtask

	task automatic test_limits_and_home;
		// Home outside a zero window: the next movement pulls it back in.
		set_cursor_window(12'd0, 12'd0, 12'hFFF, 12'hFFF);
		send_item(ps2mct_pkg::OP_INIT, 8'h5A);
		send_packet(8'h01, 8'h00, 8'h01);
		set_cursor_window(12'hFFF, 12'hFFF, 12'd0, 12'd0);
		send_item(ps2mct_pkg::OP_INIT, 8'h00);
		send_packet(8'h03, 8'h80, 8'h7F);
		set_cursor_window(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		send_item(ps2mct_pkg::OP_INIT, 8'hFF);
		send_packet(8'h04, 8'h7F, 8'h80);
	endtask

	task automatic test_random_traffic;
		int start;
		for (int round = 0; round < 4; round++) begin
			case (round)
				0: set_cursor_window(12'hFFF, 12'hFFF, rand_coord(4095),
						rand_coord(4095));
				1: set_cursor_window(rand_coord(40), rand_coord(40),
						rand_coord(4095), rand_coord(4095));
				2: set_cursor_window(rand_coord(4095), rand_coord(4095),
						rand_coord(4095), rand_coord(4095));
				default: set_cursor_window(
						ps2mct_pkg::out_coord_t'(ps2mct_pkg::MAX_X_RST),
						ps2mct_pkg::out_coord_t'(ps2mct_pkg::MAX_Y_RST),
						ps2mct_pkg::out_coord_t'(ps2mct_pkg::HOME_X_RST),
						ps2mct_pkg::out_coord_t'(ps2mct_pkg::HOME_Y_RST));
			endcase
			start = items_sent;
			while (items_sent - start < ROUND_ITEMS) begin
				case ($urandom_range(0, 15))
					0: send_item(ps2mct_pkg::OP_INIT, 8'($urandom_range(0, 255)));
					// A stray byte shifts the framing of everything after it.
					1: send_item(ps2mct_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
					2: begin
						send_item(ps2mct_pkg::OP_RX_BYTE, pick_header());
						send_item(ps2mct_pkg::OP_RX_BYTE, pick_delta());
					end
					default: send_packet(pick_header(), pick_delta(), pick_delta());
				endcase
			end
		end
	endtask

	// The receiver holds off while every packet moves the cursor, so the
	// result register fills and the block must stall its input.
	task automatic test_backpressure;
		drain_results();
		hold_request = 1'b1;
		wait (holding);
		repeat (30)
			send_packet(pick_header(), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
	endtask

	task automatic test_steady_stream;
		drain_results();
		tx_bursts = 1'b0;
		rx_bursts = 1'b0;
		repeat (40)
			send_packet(pick_header(), pick_delta(), pick_delta());
	endtask

	// Receiver: random stall bursts, or one long hold-off on request.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				holding      = 1'b1;
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holding      = 1'b0;
				result_stall = 1'b0;
			end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
				result_stall = 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				result_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_moves.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual x=%0d y=%0d b=%0d",
					$time, result.cursor_x, result.cursor_y, result.buttons);
				errors++;
			end else begin
				oldest_move = pending_moves.pop_front();
				if (result.cursor_x !== oldest_move.cursor_x) begin
					$display("%0t: cursor_x expected %0d, actual %0d", $time,
						oldest_move.cursor_x, result.cursor_x);
					errors++;
				end
				if (result.cursor_y !== oldest_move.cursor_y) begin
					$display("%0t: cursor_y expected %0d, actual %0d", $time,
						oldest_move.cursor_y, result.cursor_y);
					errors++;
				end
				if (result.buttons !== oldest_move.buttons) begin
					$display("%0t: buttons expected %0d, actual %0d", $time,
						oldest_move.buttons, result.buttons);
					errors++;
				end
				results_checked++;
			end
		end
	end

	// Watchdog: any transfer or register write restarts the count.
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: watchdog expired with %0d results outstanding", $time,
			pending_moves.size());
		$display("ps2_mouse_cursor_tracker_unit regression: fail");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		lim_x      = ps2mct_pkg::out_coord_t'(ps2mct_pkg::MAX_X_RST);
		lim_y      = ps2mct_pkg::out_coord_t'(ps2mct_pkg::MAX_Y_RST);
		home_col   = ps2mct_pkg::out_coord_t'(ps2mct_pkg::HOME_X_RST);
		home_row   = ps2mct_pkg::out_coord_t'(ps2mct_pkg::HOME_Y_RST);
		cur_x      = ps2mct_pkg::out_coord_t'(ps2mct_pkg::HOME_X_RST);
		cur_y      = ps2mct_pkg::out_coord_t'(ps2mct_pkg::HOME_Y_RST);
		pkt_phase  = ps2mct_pkg::PH_DY;
		held_dx    = '0;
		btn_now    = '0;
		btn_prev   = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_limits_and_home();
		test_random_traffic();
		test_backpressure();
		test_steady_stream();
		drain_results();

		$display("Sent %0d items (packets, init commands, stray and cut-short bytes),",
			items_sent);
		$display("%0d register writes; checked %0d cursor results under idle bursts",
			reg_writes, results_checked);
		$display("and one long result hold-off.");
		if (errors == 0)
			$display("ps2_mouse_cursor_tracker_unit regression: pass");
		else
			$display("ps2_mouse_cursor_tracker_unit regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
sv/ps2mct_pkg.sv
sv/ps2mct_clamp.sv
sv/ps2_mouse_cursor_tracker_unit.sv
test/testbench.sv
